>>> rtl/column_texel_scaler_macros.svh
// Assertion helpers for the column texel scaler.
`ifndef COLUMN_TEXEL_SCALER_MACROS_SVH
`define COLUMN_TEXEL_SCALER_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define CTS_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("column_texel_scaler: same-cycle check failed");

// Next-cycle implication, disabled in reset.
`define CTS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("column_texel_scaler: next-cycle check failed");

`endif

>>> rtl/cts_pkg.sv
package cts_pkg;

    // Source column geometry
    localparam int unsigned SRC_TEXELS = 64;
    localparam int unsigned SRC_SHIFT  = $clog2(SRC_TEXELS);

    // Field widths
    localparam int unsigned IDX_W  = 6;
    localparam int unsigned H_W    = 9;
    localparam int unsigned V_W    = 8;
    localparam int unsigned ADDR_W = 16;
    localparam int unsigned PIX_W  = 8;
    localparam int unsigned MASK_W = 4;

    // Config port
    localparam int unsigned PADDR_W = 3;
    localparam int unsigned PDATA_W = 32;

    localparam logic [H_W-1:0] H_RESET = 9'd64;
    localparam logic [V_W-1:0] V_RESET = 8'd160;

    // Rows per texel are capped at this count
    localparam int unsigned MAX_ROWS = 8;
    localparam int unsigned CNT_W    = $clog2(MAX_ROWS);

    typedef enum logic {
        REG_SCALED_HEIGHT = 1'b0,
        REG_VIEW_HEIGHT   = 1'b1
    } reg_idx_t;

endpackage

>>> rtl/column_texel_scaler.sv
// column_texel_scaler: nearest-neighbor vertical scaler for a 64-texel column.
// Input channel (in_valid/in_ready) takes one texel word: index, value,
// destination column offset and plane mask. Output channel (out_valid/
// out_ready) returns one write word per visible row the texel covers, at
// most 8, in increasing row order, last_row set on the texel's final word.
// A texel whose rows are all clipped, or that covers no row, yields nothing.
// Config: APB-style, scaled_height at 0x0, view_height at 0x4; write only idle.
// Timing: in_ready drops for the whole texel. Accept -> CALC (one 6x9
// multiply plus add, shared for both row bounds) -> CLIP (clip and base
// address multiply) -> EMIT. The first write word is registered on entry
// to EMIT; then one word per cycle while out_ready is high. An empty texel
// goes from CLIP straight back to idle.
// A stalled receiver simply holds the current word; the sequencer waits in
// EMIT and input stays blocked until the last word of the texel is taken.
// Reset (rst_n low, asynchronous) returns to idle with no word pending and
// loads scaled_height = 64, view_height = 160.
`include "column_texel_scaler_macros.svh"

module column_texel_scaler #(
    parameter int unsigned ROW_BYTES = 80
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // config port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [cts_pkg::PADDR_W-1:0]   paddr,
    input  logic [cts_pkg::PDATA_W-1:0]   pwdata,
    output logic [cts_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready,
    // texel input
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [cts_pkg::IDX_W-1:0]     texel_index,
    input  logic [cts_pkg::PIX_W-1:0]     texel_value,
    input  logic [cts_pkg::ADDR_W-1:0]    column_offset,
    input  logic [cts_pkg::MASK_W-1:0]    plane_mask,
    // write output
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [cts_pkg::ADDR_W-1:0]    write_address,
    output logic [cts_pkg::V_W-1:0]       row_index,
    output logic [cts_pkg::PIX_W-1:0]     pixel_value,
    output logic [cts_pkg::MASK_W-1:0]    write_mask,
    output logic                          last_row
);

    localparam logic [cts_pkg::ADDR_W-1:0] ROW_STEP = cts_pkg::ADDR_W'(ROW_BYTES);
    localparam int unsigned PROD_W = cts_pkg::IDX_W + cts_pkg::H_W + 1;
    localparam int unsigned ROWS_W = 11;   // signed virtual row, covers -255..638
    localparam int unsigned MUL_W  = cts_pkg::V_W + cts_pkg::ADDR_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CALC,
        ST_CLIP,
        ST_EMIT
    } state_t;

    // ------------------------------------------------------------------
    // Config registers
    // ------------------------------------------------------------------
    logic [cts_pkg::H_W-1:0] h_reg;
    logic [cts_pkg::V_W-1:0] v_reg;
    logic                    cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            h_reg <= cts_pkg::H_RESET;
            v_reg <= cts_pkg::V_RESET;
        end
        else if (cfg_wr)
        begin
            case (cts_pkg::reg_idx_t'(paddr[2]))
                cts_pkg::REG_SCALED_HEIGHT: h_reg <= pwdata[cts_pkg::H_W-1:0];
                cts_pkg::REG_VIEW_HEIGHT:   v_reg <= pwdata[cts_pkg::V_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (cts_pkg::reg_idx_t'(paddr[2]))
            cts_pkg::REG_SCALED_HEIGHT:
                prdata = {{(cts_pkg::PDATA_W-cts_pkg::H_W){1'b0}}, h_reg};
            cts_pkg::REG_VIEW_HEIGHT:
                prdata = {{(cts_pkg::PDATA_W-cts_pkg::V_W){1'b0}}, v_reg};
            default:
                prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer and datapath registers
    // ------------------------------------------------------------------
    state_t                     state_reg,  state_next;
    logic [cts_pkg::IDX_W-1:0]  idx_reg,    idx_next;
    logic [cts_pkg::PIX_W-1:0]  val_reg,    val_next;
    logic [cts_pkg::ADDR_W-1:0] off_reg,    off_next;
    logic [cts_pkg::MASK_W-1:0] msk_reg,    msk_next;
    logic signed [ROWS_W-1:0]   start_reg,  start_next;
    logic signed [ROWS_W-1:0]   end_reg,    end_next;
    logic [cts_pkg::V_W-1:0]    row_reg,    row_next;
    logic [cts_pkg::ADDR_W-1:0] addr_reg,   addr_next;
    logic [cts_pkg::CNT_W-1:0]  cnt_reg,    cnt_next;
    logic                       valid_reg,  valid_next;

    // centering offset: (v - h) / 2 truncated toward zero
    logic signed [cts_pkg::H_W:0]   diff;
    logic signed [cts_pkg::H_W:0]   diff_adj;
    logic signed [cts_pkg::H_W-1:0] top;

    assign diff     = $signed({2'b00, v_reg}) - $signed({1'b0, h_reg});
    assign diff_adj = diff + $signed({{cts_pkg::H_W{1'b0}}, diff[cts_pkg::H_W]});
    assign top      = cts_pkg::H_W'(diff_adj >>> 1);

    // shared multiply/add: idx*h, then idx*h + h gives the next texel's bound
    logic [PROD_W-1:0]          prod;
    logic [PROD_W-1:0]          prod_hi;
    logic [cts_pkg::H_W:0]      lo_rows;
    logic [cts_pkg::H_W:0]      hi_rows;
    logic signed [ROWS_W-1:0]   top_ext;

    assign prod    = PROD_W'(idx_reg) * PROD_W'(h_reg);
    assign prod_hi = prod + PROD_W'(h_reg);
    assign lo_rows = (cts_pkg::H_W+1)'(prod    >> cts_pkg::SRC_SHIFT);
    assign hi_rows = (cts_pkg::H_W+1)'(prod_hi >> cts_pkg::SRC_SHIFT);
    assign top_ext = ROWS_W'(top);

    // clipping against the view
    logic signed [ROWS_W-1:0]   v_ext;
    logic signed [ROWS_W-1:0]   start_clip;
    logic signed [ROWS_W-1:0]   end_clip;
    logic                       has_rows;
    logic [MUL_W-1:0]           base_mul;

    assign v_ext      = $signed({{(ROWS_W-cts_pkg::V_W){1'b0}}, v_reg});
    assign start_clip = (start_reg < 0) ? '0 : start_reg;
    assign end_clip   = (end_reg > v_ext) ? v_ext : end_reg;
    assign has_rows   = start_clip < end_clip;
    assign base_mul   = MUL_W'(start_clip[cts_pkg::V_W-1:0]) * MUL_W'(ROW_STEP);

    // last word of the texel: next row past the bound or row cap reached
    logic [ROWS_W-1:0] row_inc;
    logic              is_last;

    assign row_inc = ROWS_W'(row_reg) + ROWS_W'(1);
    assign is_last = ($signed(row_inc) >= end_reg) ||
                     (cnt_reg == cts_pkg::CNT_W'(cts_pkg::MAX_ROWS - 1));

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        val_next   = val_reg;
        off_next   = off_reg;
        msk_next   = msk_reg;
        start_next = start_reg;
        end_next   = end_reg;
        row_next   = row_reg;
        addr_next  = addr_reg;
        cnt_next   = cnt_reg;
        valid_next = valid_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    idx_next   = texel_index;
                    val_next   = texel_value;
                    off_next   = column_offset;
                    msk_next   = plane_mask;
                    state_next = ST_CALC;
                end
            end
            ST_CALC:
            begin
                start_next = $signed(ROWS_W'(lo_rows)) + top_ext;
                end_next   = $signed(ROWS_W'(hi_rows)) + top_ext;
                state_next = ST_CLIP;
            end
            ST_CLIP:
            begin
                end_next  = end_clip;
                row_next  = start_clip[cts_pkg::V_W-1:0];
                addr_next = off_reg + base_mul[cts_pkg::ADDR_W-1:0];
                cnt_next  = '0;
                if (has_rows)
                begin
                    valid_next = 1'b1;
                    state_next = ST_EMIT;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_EMIT:
            begin
                if (out_ready)
                begin
                    if (is_last)
                    begin
                        valid_next = 1'b0;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        row_next  = row_inc[cts_pkg::V_W-1:0];
                        addr_next = addr_reg + ROW_STEP;
                        cnt_next  = cnt_reg + cts_pkg::CNT_W'(1);
                    end
                end
            end
            default:
            begin
                valid_next = 1'b0;
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            valid_reg <= 1'b0;
            cnt_reg   <= '0;
            idx_reg   <= '0;
            val_reg   <= '0;
            off_reg   <= '0;
            msk_reg   <= '0;
            start_reg <= '0;
            end_reg   <= '0;
            row_reg   <= '0;
            addr_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            cnt_reg   <= cnt_next;
            idx_reg   <= idx_next;
            val_reg   <= val_next;
            off_reg   <= off_next;
            msk_reg   <= msk_next;
            start_reg <= start_next;
            end_reg   <= end_next;
            row_reg   <= row_next;
            addr_reg  <= addr_next;
        end
    end

    assign in_ready      = (state_reg == ST_IDLE);
    assign out_valid     = valid_reg;
    assign write_address = addr_reg;
    assign row_index     = row_reg;
    assign pixel_value   = val_reg;
    assign write_mask    = msk_reg;
    assign last_row      = is_last;

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    // every emitted row lies inside the view
    `CTS_ASSERT_NOW(a_row_in_view, out_valid, row_index < v_reg)
    // a taken word that is not the last is followed by the next row
    `CTS_ASSERT_NEXT(a_row_step, out_valid && out_ready && !last_row,
        out_valid && (row_index == $past(row_index) + 8'd1))
    // address advances by one row stride between words of a texel
    `CTS_ASSERT_NEXT(a_addr_step, out_valid && out_ready && !last_row,
        write_address == $past(write_address) + ROW_STEP)
    // after the last word the block is free for the next texel
    `CTS_ASSERT_NEXT(a_last_frees, out_valid && out_ready && last_row,
        in_ready && !out_valid)
    // no output word is pending while input is open
    `CTS_ASSERT_NOW(a_ready_no_word, in_ready, !out_valid)

endmodule

>>> tb/sv/column_texel_scaler_tb.sv
`timescale 1ns / 100ps

module column_texel_scaler_tb;

    // Must match the block's default ROW_BYTES.
    localparam int unsigned ROW_STRIDE = 80;
    // Cycles with no handshake of any kind before the run is abandoned.
    // The longest quiet stretch in a correct run is an input gap, the front
    // end, an output stall and the idle pause before a register write; the
    // limit leaves a wide margin over that.
    localparam int unsigned QUIET_LIMIT = 2000;
    // Cycles allowed after the last expected word before the block counts
    // as idle; enough to cover an empty texel still in the front end.
    localparam int unsigned SETTLE_CYCLES = 8;

    // One texel word as presented on the input channel.
    typedef struct packed {
        logic [cts_pkg::IDX_W-1:0]  index;
        logic [cts_pkg::PIX_W-1:0]  value;
        logic [cts_pkg::ADDR_W-1:0] offset;
        logic [cts_pkg::MASK_W-1:0] mask;
    } texel_t;

    // One row write word as returned on the output channel.
    typedef struct packed {
        logic [cts_pkg::ADDR_W-1:0] address;
        logic [cts_pkg::V_W-1:0]    row;
        logic [cts_pkg::PIX_W-1:0]  pixel;
        logic [cts_pkg::MASK_W-1:0] mask;
        logic                       last;
    } row_write_t;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;

    logic                          psel = 1'b0;
    logic                          penable = 1'b0;
    logic                          pwrite = 1'b0;
    logic [cts_pkg::PADDR_W-1:0]   paddr = '0;
    logic [cts_pkg::PDATA_W-1:0]   pwdata = '0;
    logic [cts_pkg::PDATA_W-1:0]   prdata;
    logic                          pready;

    logic                          in_valid = 1'b0;
    logic                          in_ready;
    logic [cts_pkg::IDX_W-1:0]     texel_index = '0;
    logic [cts_pkg::PIX_W-1:0]     texel_value = '0;
    logic [cts_pkg::ADDR_W-1:0]    column_offset = '0;
    logic [cts_pkg::MASK_W-1:0]    plane_mask = '0;

    logic                          out_valid;
    logic                          out_ready = 1'b0;
    logic [cts_pkg::ADDR_W-1:0]    write_address;
    logic [cts_pkg::V_W-1:0]       row_index;
    logic [cts_pkg::PIX_W-1:0]     pixel_value;
    logic [cts_pkg::MASK_W-1:0]    write_mask;
    logic                          last_row;

    // Shadow copy of the geometry registers, updated on each config write.
    logic [cts_pkg::H_W-1:0]       height_cfg = cts_pkg::H_RESET;
    logic [cts_pkg::V_W-1:0]       view_cfg = cts_pkg::V_RESET;

    texel_t               texel_backlog[$];   // words not yet on the bus
    row_write_t           pending_writes[$];  // predicted row writes, oldest first
    texel_t               texel_on_bus;
    int unsigned          texels_queued = 0;
    int unsigned          texels_taken = 0;
    int unsigned          error_count = 0;
    int unsigned          in_gap = 0;
    int unsigned          out_stall = 0;
    int unsigned          quiet_cycles = 0;
    bit                   bursty = 1'b1;      // random idling on both sides

    column_texel_scaler uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .texel_index  (texel_index),
        .texel_value  (texel_value),
        .column_offset(column_offset),
        .plane_mask   (plane_mask),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .write_address(write_address),
        .row_index    (row_index),
        .pixel_value  (pixel_value),
        .write_mask   (write_mask),
        .last_row     (last_row)
    );

    always #10 clk = ~clk;

    // Row writes one texel produces under the current geometry.
    // Texel i spans virtual rows floor(i*h/64) .. floor((i+1)*h/64)-1,
    // shifted by top = (v-h)/2 truncated toward zero (may go negative),
    // then clipped to 0..v-1 and capped at MAX_ROWS words.
    function automatic void scale_texel(input texel_t t);
        int h;
        int v;
        int top;
        int first;
        int stop;
        int n;
        row_write_t w;
        h = int'(height_cfg);
        v = int'(view_cfg);
        top = (v - h) / 2;
        first = (int'(t.index) * h) / int'(cts_pkg::SRC_TEXELS) + top;
        stop = ((int'(t.index) + 1) * h) / int'(cts_pkg::SRC_TEXELS) + top;
        if (first < 0)
            first = 0;
        if (stop > v)
            stop = v;
        n = 0;
        for (int r = first; r < stop && n < int'(cts_pkg::MAX_ROWS); r++)
        begin
            w.address = cts_pkg::ADDR_W'(int'(t.offset) + r * int'(ROW_STRIDE));
            w.row     = cts_pkg::V_W'(r);
            w.pixel   = t.value;
            w.mask    = t.mask;
            w.last    = (r + 1 >= stop) || (n + 1 == int'(cts_pkg::MAX_ROWS));
            pending_writes.push_back(w);
            n++;
        end
    endfunction

    function automatic void note_mismatch(input string what, input row_write_t want,
                                          input row_write_t got);
        error_count++;
        if (error_count <= 10)
            $display({"MISMATCH %s @%0t: exp addr=%h row=%0d pix=%h mask=%h last=%b",
                      " | got addr=%h row=%0d pix=%h mask=%h last=%b"},
                     what, $time, want.address, want.row, want.pixel, want.mask,
                     want.last, got.address, got.row, got.pixel, got.mask, got.last);
    endfunction

    // ------------------------------------------------------------------
    // Input driver: presents backlog words in order. Once valid is up the
    // word holds until in_ready takes it; idle gaps only start after a
    // handshake, never by pulling valid back.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_gap = 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                scale_texel(texel_on_bus);
                texels_taken++;
            end
            if (!in_valid || in_ready)
            begin
                if (in_gap > 0)
                begin
                    in_valid <= 1'b0;
                    in_gap--;
                end
                else if (texel_backlog.size() != 0)
                begin
                    texel_on_bus = texel_backlog.pop_front();
                    in_valid      <= 1'b1;
                    texel_index   <= texel_on_bus.index;
                    texel_value   <= texel_on_bus.value;
                    column_offset <= texel_on_bus.offset;
                    plane_mask    <= texel_on_bus.mask;
                    // gap after this word, so idling lands on every phase
                    if (bursty && $urandom_range(0, 4) == 0)
                        in_gap = $urandom_range(1, 17);
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Output monitor: every accepted write word is checked against the
    // oldest prediction; ready stalls come in random bursts.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        row_write_t got;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            out_stall = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                got = {write_address, row_index, pixel_value, write_mask, last_row};
                if (pending_writes.size() == 0)
                    note_mismatch("unexpected word", '0, got);
                else if (got != pending_writes[0])
                    note_mismatch("field", pending_writes[0], got);
                if (pending_writes.size() != 0)
                    void'(pending_writes.pop_front());
            end
            if (out_stall > 0)
            begin
                out_ready <= 1'b0;
                out_stall--;
            end
            else
            begin
                out_ready <= 1'b1;
                if (bursty && $urandom_range(0, 5) == 0)
                    out_stall = $urandom_range(1, 17);
            end
        end
    end

    // Watchdog: any handshake on either channel or the config port counts
    // as progress.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles == QUIET_LIMIT)
            begin
                $display("Timeout: no handshake for %0d cycles", QUIET_LIMIT);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    task automatic queue_texel(input int idx, input int val, input int off, input int msk);
        texel_t t;
        t.index  = cts_pkg::IDX_W'(idx);
        t.value  = cts_pkg::PIX_W'(val);
        t.offset = cts_pkg::ADDR_W'(off);
        t.mask   = cts_pkg::MASK_W'(msk);
        texels_queued++;
        texel_backlog.push_back(t);
    endtask

    // Everything queued is taken and every predicted word has come back;
    // then allow for an empty texel still in the front end.
    task automatic wait_drained();
        while (texels_taken != texels_queued || pending_writes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Setup then access cycle; the register takes the value at the edge
    // that closes the access cycle. Upper data bits carry noise, which the
    // register must drop.
    task automatic apb_write(input cts_pkg::reg_idx_t r,
                             input logic [cts_pkg::PDATA_W-1:0] d);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {r, 2'b00};
        pwdata  <= d;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (r == cts_pkg::REG_SCALED_HEIGHT)
            height_cfg = d[cts_pkg::H_W-1:0];
        else
            view_cfg = d[cts_pkg::V_W-1:0];
    endtask

    task automatic set_geometry(input int h, input int v);
        logic [cts_pkg::PDATA_W-1:0] d;
        wait_drained();
        d = $urandom();
        d[cts_pkg::H_W-1:0] = cts_pkg::H_W'(h);
        apb_write(cts_pkg::REG_SCALED_HEIGHT, d);
        d = $urandom();
        d[cts_pkg::V_W-1:0] = cts_pkg::V_W'(v);
        apb_write(cts_pkg::REG_VIEW_HEIGHT, d);
    endtask

    // Mostly runs of consecutive texels of one column (shared offset and
    // mask, fresh values), as a renderer would send them; one pick in five
    // is a single fully random word.
    task automatic queue_random_columns(input int count);
        int left;
        int run;
        int idx;
        int off;
        int msk;
        left = count;
        while (left > 0)
        begin
            if ($urandom_range(0, 4) == 0)
            begin
                queue_texel($urandom_range(0, 63), $urandom_range(0, 255),
                            $urandom_range(0, 65535), $urandom_range(0, 15));
                left--;
            end
            else
            begin
                run = $urandom_range(1, 12);
                idx = $urandom_range(0, 63);
                off = $urandom_range(0, 65535);
                msk = $urandom_range(0, 15);
                for (int k = 0; k < run && left > 0; k++)
                begin
                    queue_texel((idx + k) % 64, $urandom_range(0, 255), off, msk);
                    left--;
                end
            end
        end
    endtask

    initial
    begin
        int h;
        int v;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Reset geometry (64 in a 160 view): one row per texel, top = 48.
        // Field extremes, address wrap and alternating bit patterns.
        queue_texel(0, 8'h00, 16'h0000, 4'h0);
        queue_texel(63, 8'hFF, 16'hFFFF, 4'hF);
        queue_texel(21, 8'hAA, 16'h5555, 4'hA);
        queue_texel(42, 8'h55, 16'hAAAA, 4'h5);
        queue_texel(31, 8'h0F, 16'hFFB0, 4'h3);

        // Tallest even column in the largest view: top = -127, seven or eight rows
        // per texel, both ends clipped, low rows wrapping the address.
        set_geometry(510, 255);
        queue_texel(0, 8'h11, 16'h1234, 4'h1);
        queue_texel(16, 8'h22, 16'hFFFF, 4'h2);
        queue_texel(32, 8'h33, 16'hF000, 4'h4);
        queue_texel(47, 8'h44, 16'hFFFF, 4'h8);
        queue_texel(63, 8'h55, 16'h0001, 4'hF);

        // Column one row taller than the view: (1-2)/2 truncates to 0,
        // so row 0 survives and row 1 is clipped.
        set_geometry(2, 1);
        queue_texel(0, 8'h80, 16'h0100, 4'h6);
        queue_texel(31, 8'h81, 16'h0200, 4'h7);
        queue_texel(32, 8'h82, 16'h0300, 4'h9);
        queue_texel(63, 8'h83, 16'h0400, 4'hB);

        // Height of one: only the last texel covers a row.
        set_geometry(1, 255);
        queue_texel(62, 8'h90, 16'h4000, 4'hC);
        queue_texel(63, 8'h91, 16'h4000, 4'hD);

        // Zero height: no texel covers anything.
        set_geometry(0, 100);
        queue_texel(10, 8'hA0, 16'h8000, 4'hE);

        // Zero view: everything clipped.
        set_geometry(511, 0);
        queue_texel(32, 8'hB0, 16'hC000, 4'h1);

        // Largest (odd) height in the largest view.
        set_geometry(511, 255);
        queue_texel(0, 8'hC0, 16'h0000, 4'h2);
        queue_texel(40, 8'hC1, 16'hFFFF, 4'h3);
        queue_texel(63, 8'hC2, 16'h7FFF, 4'h4);

        // Random geometry per phase, mostly legal even heights with an
        // occasional out-of-range height or zero view. The last phase runs
        // with no idling on either side.
        for (int p = 0; p < 8; p++)
        begin
            h = 2 * $urandom_range(1, 255);
            v = $urandom_range(1, 255);
            case ($urandom_range(0, 5))
                0: h = $urandom_range(0, 511);
                1: v = $urandom_range(0, 255);
                default: ;
            endcase
            set_geometry(h, v);
            if (p == 7)
                bursty = 1'b0;
            queue_random_columns(16);
        end

        wait_drained();
        repeat (2 * SETTLE_CYCLES) @(posedge clk);
        if (pending_writes.size() != 0)
        begin
            $display("%0d predicted words never arrived", pending_writes.size());
            error_count += pending_writes.size();
        end
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
